>>> hdl/cdf_pkg.sv
package cdf_pkg;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP_WAIT,
    S_RD_L,
    S_RD_R,
    S_RD_C,
    S_LOAD,
    S_MUL,
    S_WR
  } back_state_e;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_REFUSED = 2'd1;
  localparam logic [1:0] ST_EMPTY   = 2'd2;

  localparam int CFG_DATA_W = 11;
  localparam int CFG_IDX_W  = 2;
  localparam logic [CFG_IDX_W-1:0] REG_VECTOR_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIRECTION     = 2'd1;
  localparam logic [CFG_DATA_W-1:0] VL_RESET = 11'd256;

  localparam int TABLE_BITS = 24;
  localparam logic [2:0] NUM_PASSES = 3'd5;

  // Constant selectors: predict 1, update 1, predict 2, update 2, K, 1/K.
  localparam logic [2:0] K_P1    = 3'd0;
  localparam logic [2:0] K_U1    = 3'd1;
  localparam logic [2:0] K_P2    = 3'd2;
  localparam logic [2:0] K_U2    = 3'd3;
  localparam logic [2:0] K_SCALE = 3'd4;
  localparam logic [2:0] K_INV   = 3'd5;

  // Magnitudes in Q2.24.
  localparam longint unsigned Q24_P1    = 64'd26610918;
  localparam longint unsigned Q24_U1    = 64'd888859;
  localparam longint unsigned Q24_P2    = 64'd14812790;
  localparam longint unsigned Q24_U2    = 64'd7440810;
  localparam longint unsigned Q24_SCALE = 64'd19287161;
  localparam longint unsigned Q24_INV   = 64'd14593904;

  typedef struct packed {
    logic       is_scale;
    logic       parity;
    logic [2:0] k;
    logic       neg;
  } pass_t;

  // Rounds a Q2.24 magnitude half up to the given number of fraction bits.
  function automatic longint unsigned coef_round(input longint unsigned q, input int f);
    longint unsigned r;
    int s;
    s = TABLE_BITS - f;
    r = q;
    if (s > 0) r = (q + (64'd1 << (s - 1))) >> s;
    return r;
  endfunction

  function automatic pass_t pass_info(input logic dir, input logic [2:0] p);
    pass_t r;
    r = '0;
    if (!dir) begin
      unique case (p)
        3'd0:    r = '{is_scale: 1'b0, parity: 1'b1, k: K_P1, neg: 1'b1};
        3'd1:    r = '{is_scale: 1'b0, parity: 1'b0, k: K_U1, neg: 1'b1};
        3'd2:    r = '{is_scale: 1'b0, parity: 1'b1, k: K_P2, neg: 1'b0};
        3'd3:    r = '{is_scale: 1'b0, parity: 1'b0, k: K_U2, neg: 1'b0};
        default: r = '{is_scale: 1'b1, parity: 1'b0, k: K_SCALE, neg: 1'b0};
      endcase
    end else begin
      unique case (p)
        3'd0:    r = '{is_scale: 1'b1, parity: 1'b0, k: K_INV, neg: 1'b0};
        3'd1:    r = '{is_scale: 1'b0, parity: 1'b0, k: K_U2, neg: 1'b1};
        3'd2:    r = '{is_scale: 1'b0, parity: 1'b1, k: K_P2, neg: 1'b1};
        3'd3:    r = '{is_scale: 1'b0, parity: 1'b0, k: K_U1, neg: 1'b0};
        default: r = '{is_scale: 1'b0, parity: 1'b1, k: K_P1, neg: 1'b0};
      endcase
    end
    return r;
  endfunction

endpackage

>>> hdl/cdf_ifs.sv
interface cdf_in_if #(
  parameter int SW = 32
);
  logic          valid;
  logic          ready;
  logic          mode;
  logic [SW-1:0] sample;

  modport source(output valid, output mode, output sample, input ready);
  modport sink(input valid, input mode, input sample, output ready);
endinterface

interface cdf_out_if #(
  parameter int SW = 32
);
  logic          valid;
  logic          ready;
  logic [SW-1:0] coefficient;
  logic          last_of_vector;
  logic [1:0]    status;

  modport source(output valid, output coefficient, output last_of_vector, output status,
                 input ready);
  modport sink(input valid, input coefficient, input last_of_vector, input status,
               output ready);
endinterface

>>> hdl/cdf_front.sv
module cdf_front #(
  parameter int SW = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  cdf_in_if.sink      in_ch_i,
  output logic        q_valid_o,
  input  logic        q_ready_i,
  output logic [SW:0] q_data_o
);
  import cdf_pkg::*;

  logic          valid_q, valid_d;
  op_e           op_q;
  logic [SW-1:0] sample_q;
  logic          accept;

  assign in_ch_i.ready = !valid_q || q_ready_i;
  assign accept        = in_ch_i.valid && in_ch_i.ready;
  assign valid_d       = accept ? 1'b1 : (valid_q && !q_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Classify the word: the mode bit picks a push or a pop command.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q     <= in_ch_i.mode ? OP_POP : OP_PUSH;
      sample_q <= in_ch_i.sample;
    end
  end

  assign q_valid_o = valid_q;
  assign q_data_o  = {op_q, sample_q};

endmodule

>>> hdl/cdf_fifo.sv
module cdf_fifo #(
  parameter int DW = 33
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_valid_i,
  output logic          wr_ready_o,
  input  logic [DW-1:0] wr_data_i,
  output logic          rd_valid_o,
  input  logic          rd_ready_i,
  output logic [DW-1:0] rd_data_o
);
  logic [DW-1:0] entry_q [2];
  logic          wptr_q, rptr_q;
  logic [1:0]    cnt_q, cnt_d;
  logic          wr, rd;

  assign wr_ready_o = (cnt_q != 2'd2);
  assign rd_valid_o = (cnt_q != 2'd0);
  assign wr         = wr_valid_i && wr_ready_o;
  assign rd         = rd_valid_o && rd_ready_i;
  assign rd_data_o  = entry_q[rptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (wr && !rd) cnt_d = cnt_q + 2'd1;
    else if (rd && !wr) cnt_d = cnt_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (wr) wptr_q <= !wptr_q;
      if (rd) rptr_q <= !rptr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) entry_q[wptr_q] <= wr_data_i;
  end

endmodule

>>> hdl/cdf_back.sv
module cdf_back #(
  parameter int SW         = 32,
  parameter int MAX_LENGTH = 1024,
  parameter int F          = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [cdf_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [cdf_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                             cmd_valid_i,
  output logic                             cmd_ready_o,
  input  logic [SW:0]                      cmd_data_i,
  cdf_out_if.source                        out_ch_o
);
  import cdf_pkg::*;

  localparam int AW  = $clog2(MAX_LENGTH);
  localparam int LW  = $clog2(MAX_LENGTH + 1);
  localparam int NW  = (LW > CFG_DATA_W) ? LW : CFG_DATA_W;
  localparam int CMW = F + 2;
  localparam int PW  = SW + 1 + CMW;
  localparam int RW  = PW - F;
  localparam int TW  = SW + 5;
  localparam logic [NW-1:0] TOP_LEN = NW'(MAX_LENGTH - (MAX_LENGTH % 2));
  localparam logic [NW-1:0] MIN_LEN = NW'(4);
  localparam logic [PW-1:0] HALF = PW'(64'd1 << (F - 1));
  localparam logic signed [TW-1:0] SAT_HI = TW'((64'sd1 <<< (SW - 1)) - 64'sd1);
  localparam logic signed [TW-1:0] SAT_LO = -SAT_HI - TW'(1);
  localparam logic [CMW-1:0] CM_P1    = CMW'(coef_round(Q24_P1, F));
  localparam logic [CMW-1:0] CM_U1    = CMW'(coef_round(Q24_U1, F));
  localparam logic [CMW-1:0] CM_P2    = CMW'(coef_round(Q24_P2, F));
  localparam logic [CMW-1:0] CM_U2    = CMW'(coef_round(Q24_U2, F));
  localparam logic [CMW-1:0] CM_SCALE = CMW'(coef_round(Q24_SCALE, F));
  localparam logic [CMW-1:0] CM_INV   = CMW'(coef_round(Q24_INV, F));

  // Configuration and vector bookkeeping.
  logic [CFG_DATA_W-1:0] vl_q;
  logic                  dir_q;
  logic [NW-1:0]         fill_q, rd_idx_q;
  logic                  ready_q;
  logic                  last_pend_q;

  // Sequencer.
  back_state_e   state_q, state_d;
  logic [2:0]    pass_q;
  logic [NW-1:0] i_q;

  // Datapath.
  logic [SW-1:0]        left_q;
  logic signed [SW:0]   sum_q;
  logic signed [SW-1:0] base_q;
  logic [PW-1:0]        prod_q;
  logic                 neg_q;
  logic [SW-1:0]        rdata_q;
  logic [SW-1:0]        mem [MAX_LENGTH];

  // Output register.
  logic          out_valid_q;
  logic [SW-1:0] coef_q;
  logic          last_q;
  logic [1:0]    status_q;

  // Combinational.
  logic [NW-1:0]  n_len, h_len, vl_ext;
  op_e            cmd_op;
  logic [SW-1:0]  cmd_sample;
  logic           take;
  logic           out_free;
  pass_t          pinfo, pnext;
  logic [NW:0]    i_next;
  logic           pass_end;
  logic [NW-1:0]  left_idx, right_idx;
  logic [2:0]     k_eff;
  logic [CMW-1:0] cm_sel;
  logic [SW:0]    mag;
  logic [RW-1:0]  r_mag;
  logic signed [TW-1:0] val, total;
  logic [SW-1:0]  wr_value;
  logic           mem_we, mem_re;
  logic [AW-1:0]  mem_waddr, mem_raddr;
  logic [SW-1:0]  mem_wdata;
  logic           out_load;
  logic [SW-1:0]  coef_d;
  logic           last_d;
  logic [1:0]     status_d;
  logic           push_done;

  // Maps a position in the low-then-high order to its place in sample order.
  function automatic logic [AW-1:0] interleave(input logic [NW-1:0] x,
                                               input logic [NW-1:0] h);
    logic          hi;
    logic [NW-1:0] t;
    hi = (x >= h);
    t  = hi ? (x - h) : x;
    return AW'({t, hi});
  endfunction

  function automatic logic [CMW-1:0] coef_of(input logic [2:0] k);
    logic [CMW-1:0] r;
    unique case (k)
      K_P1:    r = CM_P1;
      K_U1:    r = CM_U1;
      K_P2:    r = CM_P2;
      K_U2:    r = CM_U2;
      K_SCALE: r = CM_SCALE;
      default: r = CM_INV;
    endcase
    return r;
  endfunction

  assign vl_ext = NW'({vl_q[CFG_DATA_W-1:1], 1'b0});
  assign n_len  = (vl_ext < MIN_LEN) ? MIN_LEN : ((vl_ext > TOP_LEN) ? TOP_LEN : vl_ext);
  assign h_len  = n_len >> 1;

  assign cmd_op     = op_e'(cmd_data_i[SW]);
  assign cmd_sample = cmd_data_i[SW-1:0];
  assign out_free   = !out_valid_q || out_ch_o.ready;
  assign take       = (state_q == S_IDLE) && cmd_valid_i && out_free;
  assign push_done  = (fill_q + NW'(1)) == n_len;

  assign pinfo     = pass_info(dir_q, pass_q);
  assign pnext     = pass_info(dir_q, pass_q + 3'd1);
  assign i_next    = {1'b0, i_q} + (pinfo.is_scale ? (NW + 1)'(1) : (NW + 1)'(2));
  assign pass_end  = i_next >= {1'b0, n_len};
  assign left_idx  = (i_q == '0) ? (i_q + NW'(1)) : (i_q - NW'(1));
  assign right_idx = ((i_q + NW'(1)) < n_len) ? (i_q + NW'(1)) : (i_q - NW'(1));
  assign k_eff     = (pinfo.is_scale && i_q[0]) ?
                     ((pinfo.k == K_SCALE) ? K_INV : K_SCALE) : pinfo.k;
  assign cm_sel    = coef_of(k_eff);
  assign mag       = sum_q[SW] ? (~sum_q + 1'b1) : sum_q;

  // Round the product to nearest, apply the sign, add and saturate.
  assign r_mag    = RW'((prod_q + HALF) >> F);
  assign val      = neg_q ? -$signed(TW'(r_mag)) : $signed(TW'(r_mag));
  assign total    = TW'(base_q) + val;
  assign wr_value = (total > SAT_HI) ? SAT_HI[SW-1:0] :
                    ((total < SAT_LO) ? SAT_LO[SW-1:0] : total[SW-1:0]);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (take) begin
          if (cmd_op == OP_POP) begin
            if (ready_q) state_d = S_POP_WAIT;
          end else if (!ready_q && push_done) begin
            state_d = pass_info(dir_q, 3'd0).is_scale ? S_RD_C : S_RD_L;
          end
        end
      end
      S_POP_WAIT: state_d = S_IDLE;
      S_RD_L:     state_d = S_RD_R;
      S_RD_R:     state_d = S_RD_C;
      S_RD_C:     state_d = pinfo.is_scale ? S_LOAD : S_MUL;
      S_LOAD:     state_d = S_MUL;
      S_MUL:      state_d = S_WR;
      S_WR: begin
        if (!pass_end) state_d = pinfo.is_scale ? S_RD_C : S_RD_L;
        else if (pass_q == NUM_PASSES - 3'd1) state_d = S_IDLE;
        else state_d = pnext.is_scale ? S_RD_C : S_RD_L;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Outputs of the sequencer: memory ports, command pop and result load.
  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = i_q[AW-1:0];
    mem_raddr = i_q[AW-1:0];
    mem_wdata = wr_value;
    out_load  = 1'b0;
    coef_d    = '0;
    last_d    = 1'b0;
    status_d  = ST_OK;
    unique case (state_q)
      S_IDLE: begin
        if (take) begin
          if (cmd_op == OP_PUSH) begin
            out_load = 1'b1;
            if (ready_q) begin
              status_d = ST_REFUSED;
            end else begin
              mem_we    = 1'b1;
              mem_waddr = dir_q ? interleave(fill_q, h_len) : fill_q[AW-1:0];
              mem_wdata = cmd_sample;
            end
          end else if (!ready_q) begin
            out_load = 1'b1;
            status_d = ST_EMPTY;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = dir_q ? rd_idx_q[AW-1:0] : interleave(rd_idx_q, h_len);
          end
        end
      end
      S_POP_WAIT: begin
        out_load = 1'b1;
        coef_d   = rdata_q;
        last_d   = last_pend_q;
      end
      S_RD_L: begin
        mem_re    = 1'b1;
        mem_raddr = left_idx[AW-1:0];
      end
      S_RD_R: begin
        mem_re    = 1'b1;
        mem_raddr = right_idx[AW-1:0];
      end
      S_RD_C: mem_re = 1'b1;
      S_WR:   mem_we = 1'b1;
      default: ;
    endcase
  end

  assign cmd_ready_o = take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      vl_q        <= VL_RESET;
      dir_q       <= 1'b0;
      fill_q      <= '0;
      rd_idx_q    <= '0;
      ready_q     <= 1'b0;
      pass_q      <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) out_valid_q <= 1'b1;
      else if (out_ch_o.ready) out_valid_q <= 1'b0;

      if (take && cmd_op == OP_PUSH && !ready_q) begin
        if (push_done) begin
          fill_q <= '0;
          pass_q <= 3'd0;
        end else begin
          fill_q <= fill_q + NW'(1);
        end
      end
      if (take && cmd_op == OP_POP && ready_q) begin
        if ((rd_idx_q + NW'(1)) == n_len) begin
          rd_idx_q <= '0;
          ready_q  <= 1'b0;
        end else begin
          rd_idx_q <= rd_idx_q + NW'(1);
        end
      end
      if (state_q == S_WR && pass_end) begin
        if (pass_q == NUM_PASSES - 3'd1) begin
          ready_q  <= 1'b1;
          rd_idx_q <= '0;
        end else begin
          pass_q <= pass_q + 3'd1;
        end
      end

      // A register write abandons any vector in progress.
      if (cfg_we_i && (cfg_idx_i == REG_VECTOR_LENGTH || cfg_idx_i == REG_DIRECTION)) begin
        if (cfg_idx_i == REG_VECTOR_LENGTH) vl_q <= cfg_data_i;
        else dir_q <= cfg_data_i[0];
        fill_q   <= '0;
        rd_idx_q <= '0;
        ready_q  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      coef_q   <= coef_d;
      last_q   <= last_d;
      status_q <= status_d;
    end
    if (take && cmd_op == OP_PUSH && !ready_q && push_done) begin
      i_q <= NW'(pass_info(dir_q, 3'd0).is_scale ? 1'b0 : pass_info(dir_q, 3'd0).parity);
    end
    if (take) last_pend_q <= (rd_idx_q + NW'(1)) == n_len;
    case (state_q)
      S_RD_R: left_q <= rdata_q;
      S_RD_C: begin
        if (!pinfo.is_scale) begin
          sum_q <= $signed({left_q[SW-1], left_q}) + $signed({rdata_q[SW-1], rdata_q});
        end
      end
      S_LOAD: sum_q <= $signed({rdata_q[SW-1], rdata_q});
      S_MUL: begin
        base_q <= pinfo.is_scale ? '0 : $signed(rdata_q);
        prod_q <= PW'(mag) * PW'(cm_sel);
        neg_q  <= sum_q[SW] ^ pinfo.neg;
      end
      S_WR: begin
        if (!pass_end) begin
          i_q <= i_next[NW-1:0];
        end else begin
          i_q <= NW'(pnext.is_scale ? 1'b0 : pnext.parity);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rdata_q <= mem[mem_raddr];
  end

  assign out_ch_o.valid          = out_valid_q;
  assign out_ch_o.coefficient    = coef_q;
  assign out_ch_o.last_of_vector = last_q;
  assign out_ch_o.status         = status_q;

endmodule

>>> hdl/cdf97_lifting_1d_transform_unit.sv
// CDF 9/7 lifting transform over one row or column of samples.
// Input channel in_ch_i: each word is a push (mode 0, a Q23.8 sample) or a
// pop (mode 1). Output channel out_ch_o returns exactly one word per input
// word: the popped coefficient with its last-of-vector flag, or a status
// code with a zero coefficient. Words enter a register stage and a
// two-entry queue, so the input keeps flowing while an output word waits.
// One word is executed at a time. The push that completes a vector
// launches the transform: five passes over the sample memory through one
// read port and one shared multiplier. Words wait in the queue meanwhile.
// Forward results are read out low half first, then high half.
// The configuration port takes vector_length (index 0) and direction
// (index 1); a write abandons the vector in progress and is meant for idle.
// Reset returns length 256, forward direction and an empty vector; the
// sample memory is not cleared. When the receiver stalls the result is
// held, and the queue fills before in_ch_i.ready drops.
module cdf97_lifting_1d_transform_unit #(
  parameter int SAMPLE_WIDTH       = 32,
  parameter int MAX_LENGTH         = 1024,
  parameter int COEF_FRACTION_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [cdf_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [cdf_pkg::CFG_DATA_W-1:0] cfg_data_i,
  cdf_in_if.sink                         in_ch_i,
  cdf_out_if.source                      out_ch_o
);
  import cdf_pkg::*;

  logic                    fe_valid, fe_ready;
  logic [SAMPLE_WIDTH:0]   fe_data;
  logic                    q_valid, q_ready;
  logic [SAMPLE_WIDTH:0]   q_data;

  cdf_front #(.SW(SAMPLE_WIDTH)) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_ch_i   (in_ch_i),
    .q_valid_o (fe_valid),
    .q_ready_i (fe_ready),
    .q_data_o  (fe_data)
  );

  cdf_fifo #(.DW(SAMPLE_WIDTH + 1)) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (fe_valid),
    .wr_ready_o (fe_ready),
    .wr_data_i  (fe_data),
    .rd_valid_o (q_valid),
    .rd_ready_i (q_ready),
    .rd_data_o  (q_data)
  );

  cdf_back #(
    .SW         (SAMPLE_WIDTH),
    .MAX_LENGTH (MAX_LENGTH),
    .F          (COEF_FRACTION_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_valid_i (q_valid),
    .cmd_ready_o (q_ready),
    .cmd_data_i  (q_data),
    .out_ch_o    (out_ch_o)
  );

`ifndef NO_ASSERTIONS
  a_accept_staged: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_ch_i.valid && in_ch_i.ready) |=> fe_valid)
    else $error("accepted word did not reach the front register");

  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_ch_o.valid && out_ch_o.status != ST_OK) |->
      (out_ch_o.coefficient == '0 && !out_ch_o.last_of_vector))
    else $error("error word carries a coefficient or last flag");

  a_last_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_ch_o.valid && out_ch_o.last_of_vector) |-> out_ch_o.status == ST_OK)
    else $error("last flag set on a failed word");

  a_queue_drains_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_ready) |-> q_valid)
    else $error("command taken from an empty queue");
`endif

endmodule
